### hdl/sector_wall_quad_generator_top_defines.svh
// Assertion macros shared by the sector wall quad generator RTL.
`ifndef SECTOR_WALL_QUAD_GENERATOR_TOP_DEFINES_SVH
`define SECTOR_WALL_QUAD_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication on clk_i, masked while rst_ni is low.
`define SWQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, masked while rst_ni is low.
`define SWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/swq_pkg.sv
// Shared types, constants and colour table of the sector wall quad generator.
`timescale 1ns / 1ps
`default_nettype none
package swq_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned LightW = 8;
  localparam int unsigned ColW   = 8;
  localparam int unsigned GapW   = 16;

  localparam logic [GapW-1:0] MinGapReset = 16'd6;

  // Vertex order a b c a c d: which of the six picks the end point / the top.
  localparam int unsigned QuadVerts = 6;
  localparam int unsigned VtxIdxW   = $clog2(QuadVerts);
  localparam logic [QuadVerts-1:0] VtxAtEnd = 6'b010110;
  localparam logic [QuadVerts-1:0] VtxAtTop = 6'b110100;
  localparam logic [VtxIdxW-1:0]   VtxLastIdx = VtxIdxW'(QuadVerts - 1);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    COL_GREY,
    COL_BROWN,
    COL_BLUE
  } colour_e;

  typedef struct packed {
    logic [ColW-1:0] r;
    logic [ColW-1:0] g;
    logic [ColW-1:0] b;
  } rgb_t;

  // One incoming wall line.
  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] z0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] z1;
    logic signed [CoordW-1:0] ff;
    logic signed [CoordW-1:0] fc;
    logic                     has_back;
    logic signed [CoordW-1:0] bf;
    logic signed [CoordW-1:0] bc;
    logic [LightW-1:0]        light;
  } item_t;

  typedef struct packed {
    logic signed [CoordW-1:0] bot;
    logic signed [CoordW-1:0] top;
    colour_e                  col;
    logic                     emit;
  } quad_t;

  // Classified line as handed from the front end to the vertex sequencer.
  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] z0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] z1;
    quad_t                    q0;
    quad_t                    q1;
    logic [LightW-1:0]        light;
    logic [CoordW-1:0]        len;
  } rec_t;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    rgb_t                     rgb;
    logic [CoordW-1:0]        tex_u;
    logic [LightW-1:0]        light;
    logic                     last;
  } vtx_t;

  function automatic rgb_t colour_rgb(colour_e c);
    rgb_t v;
    case (c)
      COL_GREY:  v = '{r: 8'd204, g: 8'd204, b: 8'd204};
      COL_BROWN: v = '{r: 8'd179, g: 8'd128, b: 8'd51};
      COL_BLUE:  v = '{r: 8'd51,  g: 8'd153, b: 8'd204};
      default:   v = '{r: 8'd204, g: 8'd204, b: 8'd204};
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### hdl/swq_front.sv
// Front end: line intake, gap classification, squares and iterative square root.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_wall_quad_generator_top_defines.svh"
module swq_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  swq_pkg::item_t            item_i,
  input  logic [swq_pkg::GapW-1:0]  min_gap_i,
  input  logic                      full_i,
  output logic                      push_o,
  output swq_pkg::rec_t             rec_o
);
  import swq_pkg::*;

  localparam int unsigned RootSteps  = 4;
  localparam int unsigned RadW       = 2 * CoordW;
  localparam int unsigned RootCycles = RadW / (2 * RootSteps);
  localparam int unsigned LeftW      = $clog2(RootCycles + 1);
  localparam int unsigned RemW       = CoordW + 1;
  localparam int unsigned TrialW     = RemW + 2;

  typedef struct packed {
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] z0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] z1;
    logic signed [CoordW-1:0] lo_bot;
    logic signed [CoordW-1:0] lo_top;
    logic signed [CoordW-1:0] hi_bot;
    logic signed [CoordW-1:0] hi_top;
    logic                     has_back;
    logic [LightW-1:0]        light;
  } geom_t;

  // stage 1: abs deltas and bounds
  logic              s1_vld_q;
  geom_t             s1_q, s1_d;
  logic [CoordW-1:0] ax_q, ax_d, az_q, az_d;
  // stage 2: squares and gaps
  logic              s2_vld_q;
  geom_t             s2_q;
  logic [RadW-1:0]   sx_q, sx_d, sz_q, sz_d;
  logic [CoordW-1:0] gap_lo_q, gap_lo_d, gap_hi_q, gap_hi_d;
  // root unit
  logic              rt_vld_q;
  logic [LeftW-1:0]  rt_left_q;
  rec_t              rt_rec_q, rt_rec_d;
  logic [RadW-1:0]   rt_rad_q, rt_rad_d;
  logic [RemW-1:0]   rt_rem_q, rt_rem_d;
  logic [CoordW-1:0] rt_root_q, rt_root_d;
  logic              rt_sat_q;

  logic            in_acc, s1_move, s2_free, rt_free, root_take, emit_lo, emit_hi;
  logic [RadW:0]   sum_w;

  assign push_o    = rt_vld_q && (rt_left_q == '0) && !full_i;
  assign rt_free   = !rt_vld_q || push_o;
  assign root_take = s2_vld_q && rt_free;
  assign s2_free   = !s2_vld_q || root_take;
  assign s1_move   = s1_vld_q && s2_free;
  assign in_stall_o = s1_vld_q && !s2_free;
  assign in_acc    = in_valid_i && !in_stall_o;

  // stage 1 logic
  always_comb begin
    ax_d = (item_i.x1 > item_i.x0) ? item_i.x1 - item_i.x0 : item_i.x0 - item_i.x1;
    az_d = (item_i.z1 > item_i.z0) ? item_i.z1 - item_i.z0 : item_i.z0 - item_i.z1;
    s1_d.x0 = item_i.x0;
    s1_d.z0 = item_i.z0;
    s1_d.x1 = item_i.x1;
    s1_d.z1 = item_i.z1;
    s1_d.has_back = item_i.has_back;
    s1_d.light = item_i.light;
    if (item_i.has_back) begin
      s1_d.lo_bot = (item_i.ff < item_i.bf) ? item_i.ff : item_i.bf;
      s1_d.lo_top = (item_i.ff > item_i.bf) ? item_i.ff : item_i.bf;
    end else begin
      // one-sided: floor to ceiling as given, even when inverted
      s1_d.lo_bot = item_i.ff;
      s1_d.lo_top = item_i.fc;
    end
    s1_d.hi_bot = (item_i.fc < item_i.bc) ? item_i.fc : item_i.bc;
    s1_d.hi_top = (item_i.fc > item_i.bc) ? item_i.fc : item_i.bc;
  end

  // stage 2 logic; gaps are below 2^32 so the wrapped difference is exact
  assign sx_d     = ax_q * ax_q;
  assign sz_d     = az_q * az_q;
  assign gap_lo_d = s1_q.lo_top - s1_q.lo_bot;
  assign gap_hi_d = s1_q.hi_top - s1_q.hi_bot;

  // root hand-over
  assign sum_w   = {1'b0, sx_q} + {1'b0, sz_q};
  assign emit_lo = !s2_q.has_back || (gap_lo_q > CoordW'(min_gap_i));
  assign emit_hi = s2_q.has_back && (gap_hi_q > CoordW'(min_gap_i));

  always_comb begin
    rt_rec_d.x0    = s2_q.x0;
    rt_rec_d.z0    = s2_q.z0;
    rt_rec_d.x1    = s2_q.x1;
    rt_rec_d.z1    = s2_q.z1;
    rt_rec_d.q0    = '{bot: s2_q.lo_bot, top: s2_q.lo_top,
                       col: (s2_q.has_back ? COL_BROWN : COL_GREY), emit: emit_lo};
    rt_rec_d.q1    = '{bot: s2_q.hi_bot, top: s2_q.hi_top, col: COL_BLUE, emit: emit_hi};
    rt_rec_d.light = s2_q.light;
    rt_rec_d.len   = '0;
  end

  // digit-by-digit root, RootSteps result bits per cycle
  always_comb begin
    logic [TrialW-1:0] rem_t, trial, diff;
    rt_rem_d  = rt_rem_q;
    rt_root_d = rt_root_q;
    rt_rad_d  = rt_rad_q;
    for (int k = 0; k < RootSteps; k++) begin
      rem_t = {rt_rem_d, rt_rad_d[RadW-1 -: 2]};
      trial = {1'b0, rt_root_d, 2'b01};
      diff  = rem_t - trial;
      if (rem_t >= trial) begin
        rt_rem_d  = diff[RemW-1:0];
        rt_root_d = {rt_root_d[CoordW-2:0], 1'b1};
      end else begin
        rt_rem_d  = rem_t[RemW-1:0];
        rt_root_d = {rt_root_d[CoordW-2:0], 1'b0};
      end
      rt_rad_d = {rt_rad_d[RadW-3:0], 2'b00};
    end
  end

  always_comb begin
    rec_o     = rt_rec_q;
    rec_o.len = rt_sat_q ? '1 : rt_root_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      rt_vld_q  <= 1'b0;
      rt_left_q <= '0;
    end else begin
      if (in_acc) begin
        s1_vld_q <= 1'b1;
      end else if (s1_move) begin
        s1_vld_q <= 1'b0;
      end
      if (s1_move) begin
        s2_vld_q <= 1'b1;
      end else if (root_take) begin
        s2_vld_q <= 1'b0;
      end
      if (root_take) begin
        rt_vld_q <= 1'b1;
      end else if (push_o) begin
        rt_vld_q <= 1'b0;
      end
      if (root_take) begin
        rt_left_q <= LeftW'(RootCycles);
      end else if (rt_left_q != '0) begin
        rt_left_q <= rt_left_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
      ax_q <= ax_d;
      az_q <= az_d;
    end
    if (s1_move) begin
      s2_q     <= s1_q;
      sx_q     <= sx_d;
      sz_q     <= sz_d;
      gap_lo_q <= gap_lo_d;
      gap_hi_q <= gap_hi_d;
    end
    if (root_take) begin
      rt_rec_q  <= rt_rec_d;
      rt_rad_q  <= sum_w[RadW-1:0];
      rt_sat_q  <= sum_w[RadW];
      rt_rem_q  <= '0;
      rt_root_q <= '0;
    end else if (rt_left_q != '0) begin
      rt_rad_q  <= rt_rad_d;
      rt_rem_q  <= rt_rem_d;
      rt_root_q <= rt_root_d;
    end
  end

  `SWQ_ASSERT_NEXT(a_root_start, root_take, rt_left_q == LeftW'(RootCycles), "root not started")
  `SWQ_ASSERT_NOW(a_push_done, push_o, rt_vld_q && rt_left_q == '0, "push before root done")

endmodule
`default_nettype wire

### hdl/swq_fifo.sv
// Short queue of classified lines between front end and vertex sequencer.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_wall_quad_generator_top_defines.svh"
module swq_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  swq_pkg::rec_t rec_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          vld_o,
  output swq_pkg::rec_t rec_o
);
  import swq_pkg::*;

  rec_t                entry_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q;

  assign full_o = (cnt_q == FifoCntW'(FifoDepth));
  assign vld_o  = (cnt_q != '0);
  assign rec_o  = entry_q[rd_ptr_q];

  function automatic logic [FifoPtrW-1:0] ptr_inc(logic [FifoPtrW-1:0] p);
    return (p == FifoPtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= rec_i;
    end
  end

  `SWQ_ASSERT_NOW(a_no_overflow, push_i, !full_o, "push into full queue")
  `SWQ_ASSERT_NOW(a_no_underflow, pop_i, vld_o, "pop from empty queue")

endmodule
`default_nettype wire

### hdl/swq_back.sv
// Vertex sequencer: walks the quads of a line and drives the output register.
`timescale 1ns / 1ps
`default_nettype none
`include "sector_wall_quad_generator_top_defines.svh"
module swq_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fifo_vld_i,
  input  swq_pkg::rec_t rec_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output swq_pkg::vtx_t vtx_o
);
  import swq_pkg::*;

  logic               cur_vld_q, quad_q;
  rec_t               cur_q;
  logic [VtxIdxW-1:0] vtx_q;
  logic               out_vld_q;
  vtx_t               out_q, vtx_d;
  quad_t              q_sel;
  logic               load_ok, emit_now, last_vtx, final_quad, done_cur, at_end, at_top;

  assign load_ok    = !out_vld_q || !out_stall_i;
  assign emit_now   = cur_vld_q && load_ok;
  assign last_vtx   = (vtx_q == VtxLastIdx);
  assign final_quad = quad_q || !cur_q.q1.emit;
  assign done_cur   = emit_now && last_vtx && final_quad;
  assign pop_o      = fifo_vld_i && (!cur_vld_q || done_cur);

  assign q_sel  = quad_q ? cur_q.q1 : cur_q.q0;
  assign at_end = VtxAtEnd[vtx_q];
  assign at_top = VtxAtTop[vtx_q];

  always_comb begin
    vtx_d.pos_x = at_end ? cur_q.x1 : cur_q.x0;
    vtx_d.pos_z = at_end ? cur_q.z1 : cur_q.z0;
    vtx_d.pos_y = at_top ? q_sel.top : q_sel.bot;
    vtx_d.rgb   = colour_rgb(q_sel.col);
    vtx_d.tex_u = at_end ? cur_q.len : '0;
    vtx_d.light = cur_q.light;
    vtx_d.last  = last_vtx && final_quad;
  end

  assign out_valid_o = out_vld_q;
  assign vtx_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      quad_q    <= 1'b0;
      vtx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (pop_o) begin
        // a line with no quad to draw is dropped here
        cur_vld_q <= rec_i.q0.emit || rec_i.q1.emit;
        quad_q    <= !rec_i.q0.emit;
        vtx_q     <= '0;
      end else if (emit_now) begin
        if (last_vtx) begin
          vtx_q <= '0;
          if (final_quad) begin
            cur_vld_q <= 1'b0;
          end else begin
            quad_q <= 1'b1;
          end
        end else begin
          vtx_q <= vtx_q + 1'b1;
        end
      end
      if (load_ok) begin
        out_vld_q <= emit_now;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= rec_i;
    end
    if (emit_now) begin
      out_q <= vtx_d;
    end
  end

  `SWQ_ASSERT_NEXT(a_vtx_stream, out_vld_q && !out_stall_i && !out_q.last, out_vld_q, "gap in vertex stream")
  `SWQ_ASSERT_NOW(a_upper_quad, cur_vld_q && quad_q, cur_q.q1.emit, "upper quad not enabled")

endmodule
`default_nettype wire

### hdl/sector_wall_quad_generator_top.sv
// Top level of the sector wall quad generator: ports, min_gap register, wiring.
//
// Input channel (in_valid_i / in_stall_o): one request per wall line. A request
// is taken on a rising edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): one request per vertex, six per
// quad in the order a b c a c d; last_o marks the line's final vertex. A
// two-sided line with neither gap above min_gap produces no vertices at all.
// Config channel (cfg_valid_i / cfg_ready_o): writes min_gap, always ready;
// write it only while the block is idle.
// A taken line passes the stage 1 and stage 2 registers, the root unit, the line
// queue, the vertex sequencer and the output register before its first vertex
// shows on out_valid_o. The square root unit retires 4 result bits per cycle and
// takes a new line only once the last one is pushed to the queue; the vertex
// sequencer loads a queued line as it emits the final vertex of the current one.
// The front end, a two-entry line queue and the output register let intake
// carry on while the receiver stalls; a stalled vertex holds steady.
// Reset (rst_ni low, asynchronous) empties every stage and sets min_gap to 6.
`timescale 1ns / 1ps
`default_nettype none
module sector_wall_quad_generator_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // line requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [swq_pkg::CoordW-1:0]   start_x_i,
  input  logic signed [swq_pkg::CoordW-1:0]   start_z_i,
  input  logic signed [swq_pkg::CoordW-1:0]   end_x_i,
  input  logic signed [swq_pkg::CoordW-1:0]   end_z_i,
  input  logic signed [swq_pkg::CoordW-1:0]   front_floor_i,
  input  logic signed [swq_pkg::CoordW-1:0]   front_ceil_i,
  input  logic                                has_back_i,
  input  logic signed [swq_pkg::CoordW-1:0]   back_floor_i,
  input  logic signed [swq_pkg::CoordW-1:0]   back_ceil_i,
  input  logic        [swq_pkg::LightW-1:0]   light_i,
  // vertex requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swq_pkg::CoordW-1:0]   pos_x_o,
  output logic signed [swq_pkg::CoordW-1:0]   pos_y_o,
  output logic signed [swq_pkg::CoordW-1:0]   pos_z_o,
  output logic        [swq_pkg::ColW-1:0]     red_o,
  output logic        [swq_pkg::ColW-1:0]     green_o,
  output logic        [swq_pkg::ColW-1:0]     blue_chan_o,
  output logic        [swq_pkg::CoordW-1:0]   tex_u_o,
  output logic signed [swq_pkg::CoordW-1:0]   tex_v_o,
  output logic        [swq_pkg::LightW-1:0]   vtx_light_o,
  output logic                                last_o,
  // config write
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic        [swq_pkg::GapW-1:0]     cfg_data_i
);
  import swq_pkg::*;

  logic [GapW-1:0] min_gap_q;
  item_t           item;
  rec_t            push_rec, pop_rec;
  logic            push, full, pop, fifo_vld;
  vtx_t            vtx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_gap_q <= MinGapReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      min_gap_q <= cfg_data_i;
    end
  end

  always_comb begin
    item.x0       = start_x_i;
    item.z0       = start_z_i;
    item.x1       = end_x_i;
    item.z1       = end_z_i;
    item.ff       = front_floor_i;
    item.fc       = front_ceil_i;
    item.has_back = has_back_i;
    item.bf       = back_floor_i;
    item.bc       = back_ceil_i;
    item.light    = light_i;
  end

  // intake, gap tests and wall length
  swq_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (item),
    .min_gap_i  (min_gap_q),
    .full_i     (full),
    .push_o     (push),
    .rec_o      (push_rec)
  );

  // decouples the root unit from a stalled output
  swq_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (push_rec),
    .full_o (full),
    .pop_i  (pop),
    .vld_o  (fifo_vld),
    .rec_o  (pop_rec)
  );

  // one vertex per cycle into the output register, unless out_stall_i holds it
  swq_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fifo_vld_i  (fifo_vld),
    .rec_i       (pop_rec),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .vtx_o       (vtx)
  );

  assign pos_x_o     = vtx.pos_x;
  assign pos_y_o     = vtx.pos_y;
  assign pos_z_o     = vtx.pos_z;
  assign red_o       = vtx.rgb.r;
  assign green_o     = vtx.rgb.g;
  assign blue_chan_o = vtx.rgb.b;
  assign tex_u_o     = vtx.tex_u;
  assign tex_v_o     = vtx.pos_y; // v follows the height
  assign vtx_light_o = vtx.light;
  assign last_o      = vtx.last;

endmodule
`default_nettype wire
